// ===== rtl/abot_pkg.sv =====
`timescale 1ns / 1ps
// abot_pkg: payload structs and configuration register codes for the
// adaptive baseline outlier tracker. No dependencies.
package abot_pkg;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               record_start;
  } in_t;

  typedef struct packed {
    logic               is_baseline;
    logic               centre_valid;
    logic signed [23:0] centre_mean;
    logic        [23:0] centre_std;
  } out_t;

  typedef enum logic [1:0] {
    CFG_WINDOW_LEN    = 2'd0,
    CFG_OUTLIER_LIMIT = 2'd1,
    CFG_BIAS          = 2'd2
  } cfg_reg_t;

  localparam logic [5:0]         WINDOW_LEN_RST    = 6'd31;
  localparam logic [5:0]         OUTLIER_LIMIT_RST = 6'd8;
  localparam logic signed [23:0] MEAN_MAX          = 24'sh7FFFFF;
  localparam logic [23:0]        STD_MAX           = 24'hFFFFFF;
  localparam logic signed [27:0] LIMIT_MAX         = 28'sd33554431;
  localparam logic signed [27:0] LIMIT_MIN         = -28'sd33554432;

endpackage

// ===== rtl/adaptive_baseline_outlier_tracker_unit.sv =====
`timescale 1ns / 1ps
// adaptive_baseline_outlier_tracker_unit: moving mean / std tracker with
// outlier rejection, built around one shared compare-subtract unit.
// Depends on abot_pkg.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  abot_pkg::in_t
//   out_     output     out_valid/out_stall abot_pkg::out_t
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item goes through ring access and update, the two products, then the
// shared subtractor for the mean divide, square root and std divide, and a
// finish that clamps the noise limit and writes the result. The first
// sample of a record goes from the update straight to the finish. A window
// rebuild adds one ring memory read per sample of the window.
// rst_n is synchronous; in_stall is high while an item is in work, and a
// finished result waits in the output register while out_stall is high.
module adaptive_baseline_outlier_tracker_unit #(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  abot_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output abot_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PW = (AW > 7) ? AW : 7;
  localparam logic [5:0] LEN_MAX = 6'((RING_DEPTH - 1 < 63) ? RING_DEPTH - 1 : 63);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_OLD, S_UPD, S_RB_RD, S_RB_SQ, S_RB_ACC,
    S_MUL1, S_MUL2, S_DIFF, S_DIVM, S_SQRT, S_DIVS, S_LIM, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [5:0]         window_len_r, outlier_limit_r;
  logic signed [23:0] bias_r;

  // record state
  logic [15:0]        ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] flag_r;
  logic signed [23:0] window_sum_r;
  logic [37:0]        square_sum_r;
  logic [5:0]         excl_r;
  logic signed [23:0] running_mean_r;
  logic [23:0]        running_std_r;
  logic signed [25:0] noise_limit_r;
  logic [6:0]         samples_seen_r;
  logic [AW-1:0]      wr_pos_r;

  // per item
  logic signed [15:0] sample_r;
  logic               rec_r;
  logic signed [23:0] prev_mean_r;
  logic [5:0]         len_r;
  logic [6:0]         ring_r;
  logic [AW-1:0]      b_r;
  logic [31:0]        sq_s_r;
  logic signed [15:0] old_r;
  logic [31:0]        sq_old_r;
  logic               base_r, valid_r;
  logic [6:0]         n_r;
  logic [AW-1:0]      rb_addr_r;
  logic [5:0]         rb_cnt_r;
  logic [15:0]        rd_data_r;

  // stats datapath
  logic [44:0]        prod1_r;
  logic signed [47:0] prod2_r;
  logic [63:0]        rad_r;
  logic               msign_r;
  logic [63:0]        wk_r;
  logic [35:0]        rem_r;
  logic [32:0]        q_r;
  logic [5:0]         cnt_r;

  abot_pkg::out_t     out_r;
  logic               out_valid_r;

  // ring index setup
  logic [AW-1:0] wp_eff, wp_w, b_c, rd_addr, rb_prev;
  logic [5:0]    len_c;
  logic [6:0]    ring_c;

  always_comb begin
    wp_eff = rec_r ? '0 : wr_pos_r;
    len_c  = (window_len_r == 6'd0) ? 6'd1 : window_len_r;
    if (len_c > LEN_MAX) begin
      len_c = LEN_MAX;
    end
    ring_c = {1'b0, len_c} + 7'd1;
    wp_w   = (PW'(wp_eff) >= PW'(ring_c)) ? '0 : wp_eff;
    b_c    = (PW'(wp_w) + PW'(1) == PW'(ring_c)) ? '0 : AW'(PW'(wp_w) + PW'(1));
    rd_addr = (state_r == S_SETUP) ? b_c : rb_addr_r;
    rb_prev = (rb_addr_r == '0) ? AW'(PW'(ring_r) - PW'(1)) : AW'(PW'(rb_addr_r) - PW'(1));
  end

  // step update
  logic signed [23:0] s24, old24;
  logic               base_c, flag_b;
  logic signed [7:0]  ex_c;
  logic [5:0]         ex_sat;
  logic signed [7:0]  n_st;
  logic               reb_c;

  always_comb begin
    s24    = {{8{sample_r[15]}}, sample_r};
    old24  = {{8{old_r[15]}}, old_r};
    base_c = $signed({{2{sample_r[15]}}, sample_r, 8'h00}) < noise_limit_r;
    flag_b = flag_r[b_r];
    ex_c   = $signed({2'b00, excl_r}) + (base_c ? 8'sd0 : 8'sd1) - (flag_b ? 8'sd0 : 8'sd1);
    if (ex_c < 8'sd0) begin
      ex_sat = 6'd0;
    end else if (ex_c > 8'sd63) begin
      ex_sat = 6'd63;
    end else begin
      ex_sat = ex_c[5:0];
    end
    n_st  = $signed({2'b00, len_r}) - $signed({2'b00, ex_sat});
    reb_c = !base_c && (ex_sat > outlier_limit_r);
  end

  // shared compare-subtract unit
  logic        sqrt_mode;
  logic [35:0] sub_a, sub_b, rem_nxt;
  logic [36:0] diff;
  logic [32:0] q_nxt;
  logic [63:0] wk_nxt;

  always_comb begin
    sqrt_mode = (state_r == S_SQRT);
    sub_a  = sqrt_mode ? {rem_r[33:0], wk_r[63:62]} : {rem_r[34:0], wk_r[63]};
    sub_b  = sqrt_mode ? {1'b0, q_r, 2'b01} : {29'b0, n_r};
    diff   = {1'b0, sub_a} - {1'b0, sub_b};
    rem_nxt = diff[36] ? sub_a : diff[35:0];
    q_nxt  = {q_r[31:0], ~diff[36]};
    wk_nxt = sqrt_mode ? {wk_r[61:0], 2'b00} : {wk_r[62:0], 1'b0};
  end

  // stats helpers
  logic signed [31:0] num_c;
  logic [31:0]        mag_c;
  logic signed [47:0] psq_c;
  logic signed [48:0] dd_c;
  logic [45:0]        dpos_c;
  logic signed [23:0] mean_c;
  logic [23:0]        std_c;
  logic signed [27:0] lim_c;

  always_comb begin
    num_c  = {window_sum_r, 8'h00};
    mag_c  = num_c[31] ? 32'(-num_c) : 32'(num_c);
    psq_c  = window_sum_r * window_sum_r;
    dd_c   = $signed({4'b0, prod1_r}) - $signed({prod2_r[47], prod2_r});
    dpos_c = dd_c[48] ? '0 : dd_c[45:0];
    if (!msign_r) begin
      mean_c = (q_nxt > 33'd8388607) ? abot_pkg::MEAN_MAX : $signed(q_nxt[23:0]);
    end else begin
      mean_c = (q_nxt > 33'd8388608) ? -abot_pkg::MEAN_MAX - 24'sd1
                                     : $signed(24'd0 - q_nxt[23:0]);
    end
    std_c = (q_nxt > 33'h0FFFFFF) ? abot_pkg::STD_MAX : q_nxt[23:0];
    lim_c = $signed({{4{running_mean_r[23]}}, running_mean_r})
          + $signed({3'b0, running_std_r, 1'b0}) + $signed({4'b0, running_std_r})
          + $signed({{4{bias_r[23]}}, bias_r});
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      ring_mem[wr_pos_r] <= sample_r;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      window_len_r    <= abot_pkg::WINDOW_LEN_RST;
      outlier_limit_r <= abot_pkg::OUTLIER_LIMIT_RST;
      bias_r          <= '0;
      flag_r          <= '1;
      window_sum_r    <= '0;
      square_sum_r    <= '0;
      excl_r          <= '0;
      running_mean_r  <= '0;
      running_std_r   <= '0;
      noise_limit_r   <= '0;
      samples_seen_r  <= '0;
      wr_pos_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          abot_pkg::CFG_WINDOW_LEN:    window_len_r    <= cfg_data[5:0];
          abot_pkg::CFG_OUTLIER_LIMIT: outlier_limit_r <= cfg_data[5:0];
          abot_pkg::CFG_BIAS:          bias_r          <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r    <= in_data.sample;
            rec_r       <= in_data.record_start;
            prev_mean_r <= running_mean_r;
            state_r     <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (rec_r) begin
            flag_r         <= '1;
            window_sum_r   <= '0;
            square_sum_r   <= '0;
            excl_r         <= '0;
            running_mean_r <= '0;
            running_std_r  <= '0;
            noise_limit_r  <= '0;
            samples_seen_r <= '0;
          end
          len_r    <= len_c;
          ring_r   <= ring_c;
          wr_pos_r <= wp_w;
          b_r      <= b_c;
          sq_s_r   <= 32'(sample_r * sample_r);
          state_r  <= S_OLD;
        end
        S_OLD: begin
          old_r    <= $signed(rd_data_r);
          sq_old_r <= 32'($signed(rd_data_r) * $signed(rd_data_r));
          state_r  <= S_UPD;
        end
        S_UPD: begin
          if (samples_seen_r == 7'd0) begin
            window_sum_r   <= s24;
            square_sum_r   <= 38'(sq_s_r);
            running_mean_r <= {sample_r, 8'h00};
            running_std_r  <= '0;
            excl_r         <= '0;
            base_r         <= 1'b0;
            valid_r        <= 1'b0;
            state_r        <= S_FIN;
          end else if (samples_seen_r < {1'b0, len_r}) begin
            window_sum_r <= window_sum_r + s24;
            square_sum_r <= square_sum_r + 38'(sq_s_r);
            excl_r       <= '0;
            base_r       <= 1'b1;
            valid_r      <= samples_seen_r >= {2'b00, len_r[5:1]};
            n_r          <= samples_seen_r + 7'd1;
            state_r      <= S_MUL1;
          end else begin
            base_r  <= base_c;
            valid_r <= 1'b1;
            if (reb_c) begin
              excl_r       <= '0;
              for (int k = 0; k < RING_DEPTH; k++) begin
                if (k < int'(ring_r)) begin
                  flag_r[k] <= 1'b1;
                end
              end
              window_sum_r <= '0;
              square_sum_r <= '0;
              rb_addr_r    <= wr_pos_r;
              rb_cnt_r     <= '0;
              state_r      <= S_RB_RD;
            end else begin
              flag_r[wr_pos_r] <= base_c;
              window_sum_r <= window_sum_r + (base_c ? s24 : 24'sd0) - (flag_b ? old24 : 24'sd0);
              square_sum_r <= square_sum_r + (base_c ? 38'(sq_s_r) : 38'd0)
                            - (flag_b ? 38'(sq_old_r) : 38'd0);
              excl_r       <= ex_sat;
              n_r          <= n_st[6:0];
              state_r      <= (n_st > 8'sd0) ? S_MUL1 : S_FIN;
            end
          end
        end
        S_RB_RD: state_r <= S_RB_SQ;
        S_RB_SQ: begin
          old_r    <= $signed(rd_data_r);
          sq_old_r <= 32'($signed(rd_data_r) * $signed(rd_data_r));
          state_r  <= S_RB_ACC;
        end
        S_RB_ACC: begin
          window_sum_r <= window_sum_r + old24;
          square_sum_r <= square_sum_r + 38'(sq_old_r);
          rb_cnt_r     <= rb_cnt_r + 6'd1;
          rb_addr_r    <= rb_prev;
          if (rb_cnt_r + 6'd1 == len_r) begin
            n_r     <= {1'b0, len_r};
            state_r <= S_MUL1;
          end else begin
            state_r <= S_RB_RD;
          end
        end
        S_MUL1: begin
          prod1_r <= 45'(n_r) * 45'(square_sum_r);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod2_r <= psq_c;
          msign_r <= num_c[31];
          wk_r    <= {{1'b0, mag_c} + 33'(n_r[6:1]), 31'b0};
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          rad_r   <= {2'b00, dpos_c, 16'h0000};
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= 6'd32;
          state_r <= S_DIVM;
        end
        S_DIVM: begin
          if (cnt_r == 6'd0) begin
            running_mean_r <= mean_c;
            wk_r    <= rad_r;
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= 6'd31;
            state_r <= S_SQRT;
          end else begin
            rem_r <= rem_nxt;
            q_r   <= q_nxt;
            wk_r  <= wk_nxt;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_SQRT: begin
          if (cnt_r == 6'd0) begin
            wk_r    <= {q_nxt[31:0], 32'h0};
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= 6'd31;
            state_r <= S_DIVS;
          end else begin
            rem_r <= rem_nxt;
            q_r   <= q_nxt;
            wk_r  <= wk_nxt;
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_DIVS: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          wk_r  <= wk_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            running_std_r <= std_c;
            state_r       <= S_LIM;
          end
        end
        S_LIM: begin
          if (lim_c > abot_pkg::LIMIT_MAX) begin
            noise_limit_r <= abot_pkg::LIMIT_MAX[25:0];
          end else if (lim_c < abot_pkg::LIMIT_MIN) begin
            noise_limit_r <= abot_pkg::LIMIT_MIN[25:0];
          end else begin
            noise_limit_r <= lim_c[25:0];
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_r.is_baseline    <= base_r;
            out_r.centre_valid   <= valid_r;
            out_r.centre_mean    <= valid_r ? prev_mean_r : 24'sd0;
            out_r.centre_std     <= valid_r ? running_std_r : 24'd0;
            wr_pos_r <= (PW'(wr_pos_r) + PW'(1) == PW'(ring_r)) ? '0 : wr_pos_r + AW'(1);
            if (samples_seen_r != 7'd127) begin
              samples_seen_r <= samples_seen_r + 7'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
